// ===== rtl/core/xts_pkg.sv =====
// ----------------------------------------------------------------------------
// xts_pkg: shared types, constants and AES helper functions
// Holds the payload structs, the S-box functions and the round helpers.
// ----------------------------------------------------------------------------
package xts_pkg;

  localparam int unsigned MaxSectorBytesDefault = 1048576;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned SectorBytesW = 21;
  localparam int unsigned SkipW = 40;

  localparam logic [CfgIdxW-1:0] CFG_DATA_KEY_LOW   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DATA_KEY_HIGH  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TWEAK_KEY_LOW  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TWEAK_KEY_HIGH = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SECTOR_BYTES   = 3'd4;

  localparam logic [SectorBytesW-1:0] SectorBytesReset = 21'd16384;
  localparam logic [7:0] GfFold = 8'h87;

  typedef struct packed {
    logic [SkipW-1:0] skip_bytes;
    logic [63:0]      start_sector;
    logic             run_start;
    logic             mode;
    logic [63:0]      block_second;
    logic [63:0]      block_first;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_second;
    logic [63:0] result_first;
  } out_item_t;

  // Request from the sequencer to the shared AES round unit.
  typedef struct packed {
    logic         start;
    logic         decrypt;
    logic [127:0] key;
    logic [127:0] data;
  } aes_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] data;
  } aes_rsp_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] s [256];
    s = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = s[x];
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] x);
    logic [7:0] s [256];
    s = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    sbox_inv = s[x];
  endfunction

  // Doubling in GF(2^128), byte 0 least significant.
  function automatic logic [127:0] gf_double(input logic [127:0] t);
    gf_double = {t[126:0], 1'b0} ^ {120'd0, (t[127] ? GfFold : 8'h00)};
  endfunction

endpackage

// ===== rtl/core/xts_aes_unit.sv =====
// ----------------------------------------------------------------------------
// xts_aes_unit: iterative AES-128 round unit
// One round per cycle, round keys derived on the fly in both directions.
// ----------------------------------------------------------------------------
module xts_aes_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  xts_pkg::aes_req_t req,
  output xts_pkg::aes_rsp_t rsp
);
  import xts_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_KEYFWD, S_ROUND, S_DONE} state_t;

  state_t       state_r;
  logic [3:0]   round_r;
  logic         dec_r;
  logic [127:0] st_r;
  logic [127:0] rk_r;
  logic [7:0]   rcon_r;

  logic [127:0] rk_fwd, rk_bwd;
  logic [127:0] enc_out, dec_out;
  logic [7:0]   rcon_prev;

  // Forward key step uses rcon_r; backward step uses the previous rcon.
  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[31:0]; w1 = k[63:32]; w2 = k[95:64]; w3 = k[127:96];
    t = {sbox(w3[7:0]), sbox(w3[31:24]), sbox(w3[23:16]), sbox(w3[15:8]) ^ rc};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    key_fwd = {w3, w2, w1, w0};
  endfunction

  function automatic logic [127:0] key_bwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[31:0]; w1 = k[63:32]; w2 = k[95:64]; w3 = k[127:96];
    w3 = w3 ^ w2; w2 = w2 ^ w1; w1 = w1 ^ w0;
    t = {sbox(w3[7:0]), sbox(w3[31:24]), sbox(w3[23:16]), sbox(w3[15:8]) ^ rc};
    w0 = w0 ^ t;
    key_bwd = {w3, w2, w1, w0};
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      t[i] = sbox(s[8*((i%4) + 4*(((i/4) + (i%4)) % 4)) +: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (last) begin
        o[32*c +: 32] = {a3, a2, a1, a0};
      end else begin
        o[32*c +: 8]    = gmul(a0, 4'd2) ^ gmul(a1, 4'd3) ^ a2 ^ a3;
        o[32*c+8 +: 8]  = a0 ^ gmul(a1, 4'd2) ^ gmul(a2, 4'd3) ^ a3;
        o[32*c+16 +: 8] = a0 ^ a1 ^ gmul(a2, 4'd2) ^ gmul(a3, 4'd3);
        o[32*c+24 +: 8] = gmul(a0, 4'd3) ^ a1 ^ a2 ^ gmul(a3, 4'd2);
      end
    end
    enc_round = o;
  endfunction

  // Inverse shift and sub, key add, then inverse mix unless last.
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [127:0] u, o;
    logic [7:0] a0, a1, a2, a3;
    for (int i = 0; i < 16; i++) begin
      u[8*i +: 8] = sbox_inv(s[8*((i%4) + 4*(((i/4) - (i%4) + 4) % 4)) +: 8]);
    end
    u = u ^ k;
    for (int c = 0; c < 4; c++) begin
      a0 = u[32*c +: 8]; a1 = u[32*c+8 +: 8]; a2 = u[32*c+16 +: 8]; a3 = u[32*c+24 +: 8];
      if (last) begin
        o[32*c +: 32] = u[32*c +: 32];
      end else begin
        o[32*c +: 8]    = gmul(a0,4'd14) ^ gmul(a1,4'd11) ^ gmul(a2,4'd13) ^ gmul(a3,4'd9);
        o[32*c+8 +: 8]  = gmul(a0,4'd9) ^ gmul(a1,4'd14) ^ gmul(a2,4'd11) ^ gmul(a3,4'd13);
        o[32*c+16 +: 8] = gmul(a0,4'd13) ^ gmul(a1,4'd9) ^ gmul(a2,4'd14) ^ gmul(a3,4'd11);
        o[32*c+24 +: 8] = gmul(a0,4'd11) ^ gmul(a1,4'd13) ^ gmul(a2,4'd9) ^ gmul(a3,4'd14);
      end
    end
    dec_round = o;
  endfunction

  function automatic logic [7:0] xtime_inv(input logic [7:0] a);
    xtime_inv = a[0] ? ({1'b0, a[7:1]} ^ 8'h8d) : {1'b0, a[7:1]};
  endfunction

  assign rcon_prev = xtime_inv(rcon_r);
  assign rk_fwd  = key_fwd(rk_r, rcon_r);
  assign rk_bwd  = key_bwd(rk_r, rcon_prev);
  assign enc_out = enc_round(st_r, round_r == 4'd10) ^ rk_fwd;
  assign dec_out = dec_round(st_r, rk_bwd, round_r == 4'd10);

  assign rsp.done = (state_r == S_DONE);
  assign rsp.data = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      round_r <= '0;
      dec_r   <= 1'b0;
      rcon_r  <= 8'h01;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (req.start) begin
            dec_r   <= req.decrypt;
            // Decryption whitens with the last round key once it is known.
            st_r    <= req.decrypt ? req.data : (req.data ^ req.key);
            rk_r    <= req.key;
            rcon_r  <= 8'h01;
            round_r <= 4'd1;
            state_r <= req.decrypt ? S_KEYFWD : S_ROUND;
          end
        end
        S_KEYFWD: begin
          // Walk the schedule to the last round key, then whiten with it.
          rk_r   <= rk_fwd;
          rcon_r <= xtime(rcon_r);
          if (round_r == 4'd10) begin
            st_r    <= st_r ^ rk_fwd;
            round_r <= 4'd1;
            state_r <= S_ROUND;
          end else begin
            round_r <= round_r + 4'd1;
          end
        end
        S_ROUND: begin
          if (dec_r) begin
            st_r   <= dec_out;
            rk_r   <= rk_bwd;
            rcon_r <= rcon_prev;
          end else begin
            st_r   <= enc_out;
            rk_r   <= rk_fwd;
            rcon_r <= xtime(rcon_r);
          end
          if (round_r == 4'd10) begin
            state_r <= S_DONE;
          end else begin
            round_r <= round_r + 4'd1;
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/xts_divider.sv =====
// ----------------------------------------------------------------------------
// xts_divider: restoring divider, one quotient bit per cycle
// Splits the skip byte count into whole sectors and a remainder.
// ----------------------------------------------------------------------------
module xts_divider #(
  parameter int unsigned DividendW = 40,
  parameter int unsigned DivisorW  = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DividendW-1:0] dividend,
  input  logic [DivisorW-1:0]  divisor,
  output logic                 done,
  output logic [DividendW-1:0] quotient,
  output logic [DivisorW-1:0]  remainder
);
  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic [CntW-1:0]      cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DividendW-1:0] q_r;
  logic [DivisorW:0]    rem_r;
  logic [DivisorW-1:0]  d_r;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    diff;

  assign trial = {rem_r[DivisorW-1:0], q_r[DividendW-1]};
  assign diff  = trial - {1'b0, d_r};

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r[DivisorW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(DividendW);
        q_r    <= dividend;
        rem_r  <= '0;
        d_r    <= divisor;
      end else if (busy_r) begin
        if (diff[DivisorW]) begin
          rem_r <= trial;
          q_r   <= {q_r[DividendW-2:0], 1'b0};
        end else begin
          rem_r <= diff;
          q_r   <= {q_r[DividendW-2:0], 1'b1};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/xts_sector_cipher_core.sv =====
// ----------------------------------------------------------------------------
// xts_sector_cipher_core: AES-128 XTS block cipher with sector tracking
// Encrypts or decrypts one 16-byte block per item with a per-sector tweak.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | in_item_t (block, mode, run fields)
//  out_    | output    | out_valid / out_ready| out_item_t (result block)
//  cfg_    | input     | cfg_wr_en            | cfg_index, cfg_data
//
// An item inside a sector passes the accepting state, a check state, the
// request state, the single shared round unit (ten rounds and a done state;
// decryption first walks ten key steps) and the result state. An item at a
// sector boundary runs the unit a second time for the tweak. A run start adds
// a skip division and, after a remainder, a tweak and one doubling per skipped
// block. Reset is synchronous and active low; it clears the state machine, the
// configuration and the sector tracking. in_ready is low while an item is at
// work and while its result waits on out_ready.
// ----------------------------------------------------------------------------
module xts_sector_cipher_core #(
  parameter int unsigned MAX_SECTOR_BYTES = xts_pkg::MaxSectorBytesDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  xts_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output xts_pkg::out_item_t              out_item,
  input  logic                            cfg_wr_en,
  input  logic [xts_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [xts_pkg::CfgDataW-1:0]    cfg_data
);
  import xts_pkg::*;

  // Size register is wide enough to hold the largest clamped sector size.
  localparam int unsigned SizeW  = $clog2(MAX_SECTOR_BYTES + 1);
  localparam int unsigned BlkW   = (SizeW > 4) ? SizeW - 4 : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DIV_WAIT, S_SKIP_TWK, S_DOUBLE, S_CHECK,
    S_TWK, S_TWK_WAIT, S_DATA, S_DATA_WAIT, S_OUT
  } state_t;

  state_t       state_r;
  logic [63:0]  dkey_lo_r, dkey_hi_r, tkey_lo_r, tkey_hi_r;
  logic [SectorBytesW-1:0] sector_bytes_r;
  logic [127:0] tweak_r;
  logic [63:0]  cur_sector_r;
  logic [BlkW:0] blocks_left_r;
  logic [SkipW-1:0] dbl_cnt_r;
  logic [SizeW-1:0] size_r;
  in_item_t     item_r;
  out_item_t    out_r;
  logic         sector_pick_r;

  aes_req_t     aes_req;
  aes_rsp_t     aes_rsp;
  logic         div_start, div_done;
  logic [SkipW-1:0] div_q;
  logic [SizeW-1:0] div_rem;
  logic [SizeW-1:0] size_clamped;
  logic [63:0]  skip_sector;
  logic [63:0]  twk_sector;

  always_comb begin
    if (sector_bytes_r < SectorBytesW'(16)) begin
      size_clamped = SizeW'(16);
    end else if ({11'd0, sector_bytes_r} > 32'(MAX_SECTOR_BYTES)) begin
      size_clamped = SizeW'(MAX_SECTOR_BYTES);
    end else begin
      size_clamped = SizeW'(sector_bytes_r);
    end
  end

  assign skip_sector = item_r.start_sector + 64'(div_q);
  assign twk_sector  = sector_pick_r ? skip_sector : cur_sector_r;

  // Tweak source: eight zero bytes then the big-endian sector number.
  always_comb begin
    aes_req = '0;
    case (state_r)
      S_SKIP_TWK, S_TWK: begin
        aes_req.start = 1'b1;
        aes_req.key   = {tkey_hi_r, tkey_lo_r};
        aes_req.data  = {{<<8{twk_sector}}, 64'd0};
      end
      S_DATA: begin
        aes_req.start   = 1'b1;
        aes_req.decrypt = item_r.mode;
        aes_req.key     = {dkey_hi_r, dkey_lo_r};
        aes_req.data    = {item_r.block_second, item_r.block_first} ^ tweak_r;
      end
      default: aes_req = '0;
    endcase
  end

  assign div_start = (state_r == S_DIV);

  xts_aes_unit u_aes (
    .clk (clk),
    .rst_n (rst_n),
    .req (aes_req),
    .rsp (aes_rsp)
  );

  xts_divider #(
    .DividendW (SkipW),
    .DivisorW  (SizeW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (item_r.skip_bytes),
    .divisor   (size_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      dkey_lo_r      <= '0;
      dkey_hi_r      <= '0;
      tkey_lo_r      <= '0;
      tkey_hi_r      <= '0;
      sector_bytes_r <= SectorBytesReset;
      tweak_r        <= '0;
      cur_sector_r   <= '0;
      blocks_left_r  <= '0;
      sector_pick_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_DATA_KEY_LOW:   dkey_lo_r <= cfg_data;
          CFG_DATA_KEY_HIGH:  dkey_hi_r <= cfg_data;
          CFG_TWEAK_KEY_LOW:  tkey_lo_r <= cfg_data;
          CFG_TWEAK_KEY_HIGH: tkey_hi_r <= cfg_data;
          CFG_SECTOR_BYTES:   sector_bytes_r <= cfg_data[SectorBytesW-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_item;
            size_r  <= size_clamped;
            state_r <= in_item.run_start ? S_DIV : S_CHECK;
          end
        end
        S_DIV: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            if (div_rem != '0) begin
              sector_pick_r <= 1'b1;
              dbl_cnt_r     <= SkipW'(div_rem[SizeW-1:4]);
              blocks_left_r <= (BlkW+1)'((size_r - div_rem) >> 4);
              state_r       <= S_SKIP_TWK;
            end else begin
              blocks_left_r <= '0;
              cur_sector_r  <= skip_sector;
              state_r       <= S_CHECK;
            end
          end
        end
        S_SKIP_TWK: state_r <= S_TWK_WAIT;
        S_DOUBLE: begin
          if (dbl_cnt_r == '0) begin
            state_r <= S_CHECK;
          end else begin
            tweak_r   <= gf_double(tweak_r);
            dbl_cnt_r <= dbl_cnt_r - 1'b1;
          end
        end
        S_CHECK: begin
          sector_pick_r <= 1'b0;
          state_r <= (blocks_left_r == '0) ? S_TWK : S_DATA;
        end
        S_TWK: state_r <= S_TWK_WAIT;
        S_TWK_WAIT: begin
          if (aes_rsp.done) begin
            tweak_r <= aes_rsp.data;
            if (sector_pick_r) begin
              cur_sector_r <= skip_sector + 64'd1;
              state_r      <= S_DOUBLE;
            end else begin
              cur_sector_r  <= cur_sector_r + 64'd1;
              blocks_left_r <= (BlkW+1)'(size_r >> 4);
              state_r       <= S_DATA;
            end
          end
        end
        S_DATA: state_r <= S_DATA_WAIT;
        S_DATA_WAIT: begin
          if (aes_rsp.done) begin
            {out_r.result_second, out_r.result_first} <= aes_rsp.data ^ tweak_r;
            tweak_r       <= gf_double(tweak_r);
            blocks_left_r <= blocks_left_r - 1'b1;
            state_r       <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/xts_cipher_checker.sv =====
// ----------------------------------------------------------------------------
// xts_cipher_checker: expected-result tracker for the XTS sector cipher
// Watches the input, result and register ports, predicts each result block
// with its own AES-128 and sector tweak logic, and compares in order.
// ----------------------------------------------------------------------------
module xts_cipher_checker
  import xts_pkg::*;
#(
  parameter int unsigned MAX_SECTOR_BYTES = xts_pkg::MaxSectorBytesDefault
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_item,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_item,
  input  logic                   cfg_wr_en,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [CfgDataW-1:0]    cfg_data,
  output int                     error_count,
  output int                     pending_blocks
);

  logic [7:0] fwd_sb [256];
  logic [7:0] inv_sb [256];

  logic [63:0]             dkey_lo, dkey_hi, tkey_lo, tkey_hi;
  logic [SectorBytesW-1:0] sector_reg;
  logic [127:0]            tweak;
  logic [63:0]             next_sector;
  int unsigned             blocks_in_sector;
  out_item_t               expected_blocks[$];

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = xt(a);
    end
    return p;
  endfunction

  // The S-boxes are derived from field inverses and the affine map.
  initial begin
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int e = 0; e < 254; e++) inv = gm(inv, x[7:0]);
      if (x == 0) inv = 8'h00;
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sb[x] = s;
      inv_sb[s] = x[7:0];
    end
  end

  function automatic logic [127:0] aes128(input logic [127:0] din, input logic [127:0] key,
                                          input logic inverse);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] rc, tmp, a0, a1, a2, a3;
    logic [127:0] dout;
    for (int i = 0; i < 16; i++) rk[i] = key[8*i +: 8];
    rc = 8'h01;
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        tmp = w[0]; w[0] = w[1]; w[1] = w[2]; w[2] = w[3]; w[3] = tmp;
        for (int j = 0; j < 4; j++) w[j] = fwd_sb[w[j]];
        w[0] = w[0] ^ rc;
        rc = xt(rc);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) s[i] = din[8*i +: 8];
    if (!inverse) begin
      for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[i];
      for (int r = 1; r <= 10; r++) begin
        for (int i = 0; i < 16; i++) t[i] = fwd_sb[s[(i%4) + 4*(((i/4) + (i%4)) % 4)]];
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          if (r < 10) begin
            s[4*c]   = gm(a0, 2) ^ gm(a1, 3) ^ a2 ^ a3;
            s[4*c+1] = a0 ^ gm(a1, 2) ^ gm(a2, 3) ^ a3;
            s[4*c+2] = a0 ^ a1 ^ gm(a2, 2) ^ gm(a3, 3);
            s[4*c+3] = gm(a0, 3) ^ a1 ^ a2 ^ gm(a3, 2);
          end else begin
            s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
          end
        end
        for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[16*r + i];
      end
    end else begin
      for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[160 + i];
      for (int r = 9; r >= 0; r--) begin
        for (int i = 0; i < 16; i++) t[i] = inv_sb[s[(i%4) + 4*(((i/4) - (i%4) + 4) % 4)]];
        for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r + i];
        if (r > 0) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            s[4*c]   = gm(a0, 14) ^ gm(a1, 11) ^ gm(a2, 13) ^ gm(a3, 9);
            s[4*c+1] = gm(a0, 9) ^ gm(a1, 14) ^ gm(a2, 11) ^ gm(a3, 13);
            s[4*c+2] = gm(a0, 13) ^ gm(a1, 9) ^ gm(a2, 14) ^ gm(a3, 11);
            s[4*c+3] = gm(a0, 11) ^ gm(a1, 13) ^ gm(a2, 9) ^ gm(a3, 14);
          end
        end
      end
    end
    for (int i = 0; i < 16; i++) dout[8*i +: 8] = s[i];
    return dout;
  endfunction

  // Tweak of a sector: eight zero bytes, then the sector number big-endian.
  function automatic logic [127:0] sector_tweak(input logic [63:0] sector);
    logic [127:0] din;
    din = '0;
    for (int i = 0; i < 8; i++) din[64 + 8*i +: 8] = sector[56 - 8*i +: 8];
    return aes128(din, {tkey_hi, tkey_lo}, 1'b0);
  endfunction

  function automatic logic [127:0] times_two(input logic [127:0] t);
    return {t[126:0], 1'b0} ^ {120'd0, (t[127] ? 8'h87 : 8'h00)};
  endfunction

  task automatic encipher_block(input in_item_t it, output out_item_t res);
    logic [63:0]  size, skip, sector, rem;
    logic [127:0] blk;
    size = sector_reg;
    if (size < 16) size = 16;
    if (size > MAX_SECTOR_BYTES) size = MAX_SECTOR_BYTES;
    if (it.run_start) begin
      skip = {24'd0, it.skip_bytes};
      sector = it.start_sector + skip / size;
      rem = skip % size;
      if (rem > 0) begin
        tweak = sector_tweak(sector);
        for (logic [63:0] n = rem / 16; n > 0; n--) tweak = times_two(tweak);
        blocks_in_sector = (size - rem) / 16;
        next_sector = sector + 1;
      end else begin
        blocks_in_sector = 0;
        next_sector = sector;
      end
    end
    // A sector boundary, including a partial sector that held no block.
    if (blocks_in_sector == 0) begin
      tweak = sector_tweak(next_sector);
      next_sector = next_sector + 1;
      blocks_in_sector = size / 16;
    end
    blk = aes128({it.block_second, it.block_first} ^ tweak, {dkey_hi, dkey_lo}, it.mode)
          ^ tweak;
    res.result_first = blk[63:0];
    res.result_second = blk[127:64];
    tweak = times_two(tweak);
    blocks_in_sector = blocks_in_sector - 1;
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count = error_count + 1;
  endtask

  initial begin
    error_count = 0;
    pending_blocks = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      dkey_lo = '0; dkey_hi = '0; tkey_lo = '0; tkey_hi = '0;
      sector_reg = SectorBytesReset;
      tweak = '0;
      next_sector = '0;
      blocks_in_sector = 0;
      expected_blocks.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_DATA_KEY_LOW:   dkey_lo = cfg_data;
          CFG_DATA_KEY_HIGH:  dkey_hi = cfg_data;
          CFG_TWEAK_KEY_LOW:  tkey_lo = cfg_data;
          CFG_TWEAK_KEY_HIGH: tkey_hi = cfg_data;
          CFG_SECTOR_BYTES:   sector_reg = cfg_data[SectorBytesW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        encipher_block(in_item, want);
        expected_blocks.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("result block with nothing expected");
        end else begin
          want = expected_blocks.pop_front();
          if (out_item.result_first !== want.result_first)
            report_mismatch($sformatf("result_first %h, expected %h",
                                      out_item.result_first, want.result_first));
          if (out_item.result_second !== want.result_second)
            report_mismatch($sformatf("result_second %h, expected %h",
                                      out_item.result_second, want.result_second));
        end
      end
    end
    pending_blocks = expected_blocks.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the XTS sector cipher core
// Runs directed and random blocks through several key and sector size
// settings under varied idling, while the checker predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
  import xts_pkg::*;

  localparam int unsigned MaxSector = xts_pkg::MaxSectorBytesDefault;
  // A run start can need about a thousand tweak doublings; the limit leaves
  // wide room above the longest run under the heaviest stalls.
  localparam int          CycleLimit = 4000000;
  localparam int          NumPhases = 7;
  localparam int          RandomPerPhase = 172;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CFG_DATA_KEY_LOW;
  logic [CfgDataW-1:0] cfg_data = '0;

  int error_count;
  int pending_blocks;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  always #5 clk = ~clk;

  xts_sector_cipher_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  xts_cipher_checker #(.MAX_SECTOR_BYTES(MaxSector)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .error_count    (error_count),
    .pending_blocks (pending_blocks)
  );

  // The result side stalls at random with the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Presents one item and holds it until accepted. Afterwards the sender may
  // go idle; otherwise valid simply stays high.
  task automatic send_block(input in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every predicted result block has come.
  // Pending is read at the falling edge so it is settled.
  task automatic drain_results();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending_blocks == 0) break;
    end
    @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [63:0] dk_lo, input logic [63:0] dk_hi,
                               input logic [63:0] tk_lo, input logic [63:0] tk_hi,
                               input logic [63:0] sector_size);
    write_reg(CFG_DATA_KEY_LOW, dk_lo);
    write_reg(CFG_DATA_KEY_HIGH, dk_hi);
    write_reg(CFG_TWEAK_KEY_LOW, tk_lo);
    write_reg(CFG_TWEAK_KEY_HIGH, tk_hi);
    write_reg(CFG_SECTOR_BYTES, sector_size);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic in_item_t block_item(input logic [63:0] first, input logic [63:0] second,
                                          input logic mode, input logic run_start,
                                          input logic [63:0] sector, input logic [39:0] skip);
    in_item_t it;
    it.block_first  = first;
    it.block_second = second;
    it.mode         = mode;
    it.run_start    = run_start;
    it.start_sector = sector;
    it.skip_bytes   = skip;
    return it;
  endfunction

  // A random block, mostly continuing the current run. Run starts pick
  // skips of whole sectors or of random byte counts.
  function automatic in_item_t random_block(input int unsigned size, input int run_pct);
    in_item_t it;
    it.block_first  = {$urandom, $urandom};
    it.block_second = {$urandom, $urandom};
    it.mode         = 1'($urandom_range(1));
    it.run_start    = ($urandom_range(99) < run_pct);
    case ($urandom_range(3))
      0:       it.start_sector = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
      1:       it.start_sector = 64'($urandom_range(20));
      default: it.start_sector = {$urandom, $urandom};
    endcase
    case ($urandom_range(9))
      0, 1:    it.skip_bytes = 40'($urandom_range(5) * size);
      2, 3, 4: it.skip_bytes = (size <= 16384) ? 40'({$urandom, $urandom})
                                               : 40'($urandom_range(8191));
      default: it.skip_bytes = (size > 65536) ? 40'($urandom_range(8191))
                                              : 40'($urandom_range(3 * size));
    endcase
    return it;
  endfunction

  initial begin
    logic [63:0] sizes [NumPhases];
    int unsigned eff_size;
    int          run_pct;

    // Sector sizes per phase: reset value, the smallest, zero (below range),
    // one not a multiple of 16, the largest, the 21-bit maximum (above range), 4096.
    sizes = '{64'd16384, 64'd16, 64'd0, 64'd100, 64'd1048576, 64'd2097151, 64'd4096};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        drain_results();
        case (p)
          1:       load_settings('1, '1, '1, '1, sizes[p]);
          default: load_settings({$urandom, $urandom}, {$urandom, $urandom},
                                 {$urandom, $urandom}, {$urandom, $urandom}, sizes[p]);
        endcase
      end
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      eff_size = (sizes[p] < 64'd16) ? 16 : (sizes[p] > 64'(MaxSector)) ? MaxSector
                                                                        : 32'(sizes[p]);
      run_pct = (eff_size > 65536) ? 3 : 8;

      if (p == 0) begin
        // Reset keys and sector size. The first blocks come before any run
        // start and so use the tweak of sector 0.
        send_block(block_item('0, '0, 1'b0, 1'b0, '0, '0));
        send_block(block_item('1, '1, 1'b1, 1'b0, '1, '1));
        send_block(block_item(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                              1'b0, 1'b1, '0, '0));
        send_block(block_item('1, '0, 1'b1, 1'b0, '0, '0));
        // Skip of exactly one sector from the last sector number: wraps to 0.
        send_block(block_item('0, '1, 1'b0, 1'b1, '1, 40'd16384));
        // Largest skip: remainder one byte short of a sector, so the
        // partial sector holds no block and a new sector begins at once.
        send_block(block_item({32'hA5A5_5A5A, 32'h0F0F_F0F0}, '1, 1'b1, 1'b1, '1, '1));
        send_block(block_item('0, '0, 1'b0, 1'b0, '0, '0));
        // Skip within a sector, with and without a remainder past a block.
        send_block(block_item(64'h8000_0000_0000_0001, 64'h1, 1'b0, 1'b1, 64'd7, 40'd16));
        send_block(block_item(64'h1, 64'h8000_0000_0000_0000, 1'b1, 1'b0, '0, '0));
        send_block(block_item('1, '1, 1'b0, 1'b1, 64'h8000_0000_0000_0000, 40'd16375));
        send_block(block_item('0, '1, 1'b1, 1'b0, '0, '0));
        send_block(block_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                              1'b1, 1'b1, 64'd1, 40'h80_0000_0000));
        send_block(block_item('0, '0, 1'b0, 1'b0, '0, '0));
      end

      for (int k = 0; k < RandomPerPhase; k++) begin
        // One mid-phase pause lets the block empty out completely.
        if (p == 1 && k == RandomPerPhase / 2) drain_results();
        send_block(random_block(eff_size, run_pct));
      end
    end

    drain_results();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
